>>> sv/rwr_pkg.sv
// Shared constants, types and helpers of the reorder window receiver.
`default_nettype none
package rwr_pkg;

	// Window of buffered out-of-order packets; must be a power of two
	localparam int WINDOW        = 32;
	localparam int IDX_W         = $clog2(WINDOW);
	localparam int PAYLOAD_BYTES = 1200;

	// Field widths
	localparam int SEQ_W    = 31;
	localparam int EXP_W    = 32;
	localparam int HANDLE_W = 16;
	localparam int BYTE_W   = 11;
	localparam int TOTAL_W  = 40;

	// Result kinds
	localparam logic KIND_RELEASE = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	// File size split into full packets and the tail length
	typedef struct packed {
		logic [EXP_W-1:0]  quot;
		logic [BYTE_W-1:0] rem;
		logic [EXP_W-1:0]  packets;
	} size_info_t;

	// One result item
	typedef struct packed {
		logic                    kind;
		logic [SEQ_W-1:0]        rel_seq;
		logic [HANDLE_W-1:0]     rel_handle;
		logic [BYTE_W-1:0]       bytes;
		logic signed [EXP_W-1:0] ack;
		logic                    done;
		logic                    last;
	} result_t;

endpackage
`default_nettype wire

>>> sv/rwr_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rwr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/rwr_div.sv
// Divider of the file size by the payload size, one reciprocal multiply per digit.
`default_nettype none
module rwr_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic [rwr_pkg::TOTAL_W-1:0]   dividend,
	output logic                               done,
	output logic      [rwr_pkg::TOTAL_W-1:0]   quot,
	output logic      [rwr_pkg::BYTE_W-1:0]    rem
);
	import rwr_pkg::*;

	// The size is split into a high digit and a 16-bit low digit. Each digit takes
	// two steps: a reciprocal multiply for the quotient digit, then a
	// multiply-subtract by the payload size for the running remainder.
	localparam int LO_W   = 16;
	localparam int NUM_W  = BYTE_W + LO_W;
	localparam int RCP_W  = 28;
	localparam int RCP_SH = NUM_W + BYTE_W;
	localparam int PROD_W = NUM_W + RCP_W;
	// Rounded-up reciprocal; exact for every numerator of NUM_W bits
	localparam longint unsigned RCP_FULL =
		((64'd1 << RCP_SH) + 64'(PAYLOAD_BYTES) - 64'd1) / 64'(PAYLOAD_BYTES);
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_FULL);

	localparam logic [1:0] ST_HI_Q = 2'd0;
	localparam logic [1:0] ST_HI_R = 2'd1;
	localparam logic [1:0] ST_LO_Q = 2'd2;
	localparam logic [1:0] ST_LO_R = 2'd3;

	logic                run_q;
	logic [1:0]          step_q;
	logic [NUM_W-1:0]    num_q;
	logic [LO_W-1:0]     lo_q;
	logic [LO_W-1:0]     hi_q;
	logic [LO_W-1:0]     dig_q;
	logic [PROD_W-1:0]   prod;
	logic [LO_W-1:0]     q_dig;
	logic [NUM_W-1:0]    back;
	logic [BYTE_W-1:0]   rem_n;

	// Quotient digit from the reciprocal, remainder from the held digit
	always_comb begin
		prod  = PROD_W'(num_q) * PROD_W'(RECIP);
		q_dig = prod[RCP_SH +: LO_W];
		back  = num_q - NUM_W'(dig_q) * NUM_W'(PAYLOAD_BYTES);
		rem_n = back[BYTE_W-1:0];
	end

	assign done = run_q && (step_q == ST_LO_R);
	assign quot = {{(TOTAL_W-2*LO_W){1'b0}}, hi_q, dig_q};
	assign rem  = rem_n;

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= ST_HI_Q;
		end else if (load) begin
			run_q  <= 1'b1;
			step_q <= ST_HI_Q;
		end else if (run_q) begin
			run_q  <= !done;
			step_q <= step_q + 2'd1;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= NUM_W'(dividend[TOTAL_W-1:LO_W]);
			lo_q  <= dividend[LO_W-1:0];
		end else if (run_q) begin
			unique case (step_q)
				ST_HI_Q: begin
					dig_q <= q_dig;
				end
				ST_HI_R: begin
					hi_q  <= dig_q;
					num_q <= {rem_n, lo_q};
				end
				ST_LO_Q: begin
					dig_q <= q_dig;
				end
				ST_LO_R: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/rwr_seq.sv
// Sequencer: classifies packets, walks the window and emits releases and acks.
`default_nettype none
module rwr_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          size_ok,
	input  wire logic [rwr_pkg::SEQ_W-1:0]     seq_num,
	input  wire logic [rwr_pkg::HANDLE_W-1:0]  payload_handle,
	input  wire logic                          cfg_valid,
	input  wire logic                          div_done,
	input  wire rwr_pkg::size_info_t           sz,
	output logic                               busy,
	output logic                               cfg_ready,
	output logic                               ram_we,
	output logic      [rwr_pkg::IDX_W-1:0]     ram_waddr,
	output logic      [rwr_pkg::HANDLE_W-1:0]  ram_wdata,
	output logic                               ram_re,
	output logic      [rwr_pkg::IDX_W-1:0]     ram_raddr,
	input  wire logic [rwr_pkg::HANDLE_W-1:0]  ram_rdata,
	output logic                               res_valid,
	output rwr_pkg::result_t                   res
);
	import rwr_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_REL  = 3'd4;

	logic [2:0]          state_q;
	logic [EXP_W-1:0]    exp_q;
	logic [WINDOW-1:0]   valid_q;
	logic                size_ok_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [HANDLE_W-1:0] hdl_q;
	logic [SEQ_W-1:0]    cur_q;
	logic                res_valid_q;
	result_t             res_q;

	logic [EXP_W-1:0]    seq_ext;
	logic [EXP_W-1:0]    seq_gap;
	logic                is_stale;
	logic                is_next;
	logic                in_win;
	logic [IDX_W-1:0]    seq_idx;
	logic [EXP_W-1:0]    nxt;
	logic [IDX_W-1:0]    nxt_idx;
	logic                take_nxt;
	logic                accept;

	// Release item for one sequence number
	function automatic result_t mk_release(input logic [SEQ_W-1:0] s,
		input logic [HANDLE_W-1:0] h, input size_info_t si);
		result_t          r;
		logic [EXP_W-1:0] s_ext;
		s_ext        = {1'b0, s};
		r.kind       = KIND_RELEASE;
		r.rel_seq    = s;
		r.rel_handle = h;
		r.bytes      = (s_ext >= si.quot) ? si.rem : BYTE_W'(PAYLOAD_BYTES);
		r.ack        = '0;
		r.done       = ((s_ext + EXP_W'(1)) >= si.packets);
		r.last       = 1'b0;
		return r;
	endfunction

	// Acknowledgement item, always the last one of its packet
	function automatic result_t mk_ack(input logic [EXP_W-1:0] a, input logic d);
		result_t r;
		r.kind       = KIND_ACK;
		r.rel_seq    = '0;
		r.rel_handle = '0;
		r.bytes      = '0;
		r.ack        = $signed(a);
		r.done       = d;
		r.last       = 1'b1;
		return r;
	endfunction

	// Classify the held packet against the expected number
	always_comb begin
		seq_ext  = {1'b0, seq_q};
		seq_gap  = seq_ext - exp_q;
		is_stale = !size_ok_q || (seq_ext < exp_q);
		is_next  = (seq_ext == exp_q);
		in_win   = (seq_gap < EXP_W'(WINDOW));
		seq_idx  = seq_q[IDX_W-1:0];
		nxt      = {1'b0, cur_q} + EXP_W'(1);
		nxt_idx  = nxt[IDX_W-1:0];
		take_nxt = !nxt[EXP_W-1] && valid_q[nxt_idx];
	end

	assign busy      = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign accept    = start && !busy;

	// Store an early packet in a free slot of the window
	assign ram_we    = (state_q == S_EVAL) && !is_stale && !is_next && in_win &&
	                   !valid_q[seq_idx];
	assign ram_waddr = seq_idx;
	assign ram_wdata = hdl_q;
	// Fetch the next buffered handle while draining
	assign ram_re    = (state_q == S_CHK) && take_nxt;
	assign ram_raddr = nxt_idx;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			exp_q       <= '0;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						state_q <= S_DIV;
					end else if (accept) begin
						state_q <= S_EVAL;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_IDLE;
					end
				end
				S_EVAL: begin
					if (is_stale) begin
						state_q <= S_IDLE;
					end else if (is_next) begin
						res_valid_q <= 1'b1;
						state_q     <= S_CHK;
					end else begin
						res_valid_q <= 1'b1;
						if (ram_we) begin
							valid_q[seq_idx] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_CHK: begin
					res_valid_q <= !take_nxt;
					if (take_nxt) begin
						valid_q[nxt_idx] <= 1'b0;
						state_q          <= S_REL;
					end else begin
						exp_q   <= nxt;
						state_q <= S_IDLE;
					end
				end
				S_REL: begin
					res_valid_q <= 1'b1;
					state_q     <= S_CHK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			size_ok_q <= size_ok;
			seq_q     <= seq_num;
			hdl_q     <= payload_handle;
		end
		case (state_q)
			S_EVAL: begin
				if (is_next) begin
					res_q <= mk_release(seq_q, hdl_q, sz);
					cur_q <= seq_q;
				end else begin
					res_q <= mk_ack(exp_q - EXP_W'(1), exp_q >= sz.packets);
				end
			end
			S_CHK: begin
				if (!take_nxt) begin
					res_q <= mk_ack({1'b0, cur_q}, nxt >= sz.packets);
				end
			end
			S_REL: begin
				res_q <= mk_release(nxt[SEQ_W-1:0], ram_rdata, sz);
				cur_q <= nxt[SEQ_W-1:0];
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> sv/reorder_window_receiver_top.sv
// Top level of the reorder window receiver.
`default_nettype none
// Receiver for packet descriptors with a 32-slot reorder window and cumulative
// acknowledgements. An item is taken when start is high and busy is low; each
// result is shown for exactly one cycle with result_valid high and cannot be
// held off by the receiver. A stale or wrong-length packet keeps busy high
// through the evaluate state and gives nothing; an early packet keeps busy high
// through the evaluate state and its acknowledgement shows in the cycle after;
// an in-order packet keeps busy high through the evaluate and check states plus
// a release and a check state for each buffered slot drained, each drained
// slot costing one handle-RAM read, and its acknowledgement shows in the cycle
// after busy drops. The next item can be taken at the end of that cycle, so
// results of one packet never overlap the next packet's. A size write on
// cfg_data keeps busy high while the divider splits the size into full packets
// and the tail length, a quotient and a remainder step for each of its two digits.
module reorder_window_receiver_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rwr_pkg::TOTAL_W-1:0]   cfg_data,
	// Packet descriptors
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          size_ok,
	input  wire logic [rwr_pkg::SEQ_W-1:0]     seq_num,
	input  wire logic [rwr_pkg::HANDLE_W-1:0]  payload_handle,
	// Results
	output logic                               result_valid,
	output logic                               kind,
	output logic      [rwr_pkg::SEQ_W-1:0]     release_seq,
	output logic      [rwr_pkg::HANDLE_W-1:0]  release_handle,
	output logic      [rwr_pkg::BYTE_W-1:0]    byte_count,
	output logic signed [rwr_pkg::EXP_W-1:0]   ack_value,
	output logic                               transfer_done,
	output logic                               last
);
	import rwr_pkg::*;

	logic                div_done;
	logic [TOTAL_W-1:0]  div_quot;
	logic [BYTE_W-1:0]   div_rem;
	logic [EXP_W-1:0]    quot_sat;
	logic [EXP_W:0]      pkt_sum;
	size_info_t          sz_q;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [HANDLE_W-1:0] ram_wdata;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	logic [HANDLE_W-1:0] ram_rdata;
	result_t             res;

	rwr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cfg_valid && cfg_ready),
		.dividend (cfg_data),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Saturate the packet counts to 32 bits
	always_comb begin
		quot_sat = (|div_quot[TOTAL_W-1:EXP_W]) ? '1 : div_quot[EXP_W-1:0];
		pkt_sum  = {1'b0, quot_sat} + (EXP_W+1)'(div_rem != '0);
	end

	// Hold the size split once the divider finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sz_q <= '0;
		end else if (div_done) begin
			sz_q.quot    <= quot_sat;
			sz_q.rem     <= div_rem;
			sz_q.packets <= pkt_sum[EXP_W] ? '1 : pkt_sum[EXP_W-1:0];
		end
	end

	rwr_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (WINDOW)
	) u_handles (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rwr_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.size_ok        (size_ok),
		.seq_num        (seq_num),
		.payload_handle (payload_handle),
		.cfg_valid      (cfg_valid),
		.div_done       (div_done),
		.sz             (sz_q),
		.busy           (busy),
		.cfg_ready      (cfg_ready),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_re         (ram_re),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.res_valid      (result_valid),
		.res            (res)
	);

	// Drive the result ports
	assign kind           = res.kind;
	assign release_seq    = res.rel_seq;
	assign release_handle = res.rel_handle;
	assign byte_count     = res.bytes;
	assign ack_value      = res.ack;
	assign transfer_done  = res.done;
	assign last           = res.last;

	// An accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after taking an item");

	// A size write keeps the block busy while dividing
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (busy && !cfg_ready))
		else $error("block not busy after a size write");

	// Only the acknowledgement closes a packet's results
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((kind == KIND_ACK) == last))
		else $error("last flag does not match acknowledgement");

	// The closing result is followed by a quiet cycle
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !result_valid)
		else $error("result right after the closing acknowledgement");

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the reorder window receiver: queued driver, predictor, result checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rwr_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	// One packet descriptor waiting to be offered
	typedef struct {
		logic                ok;
		logic [SEQ_W-1:0]    seq;
		logic [HANDLE_W-1:0] hdl;
	} desc_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [TOTAL_W-1:0]    cfg_data = '0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  size_ok = 1'b0;
	logic [SEQ_W-1:0]      seq_num = '0;
	logic [HANDLE_W-1:0]   payload_handle = '0;
	logic                  result_valid;
	logic                  kind;
	logic [SEQ_W-1:0]      release_seq;
	logic [HANDLE_W-1:0]   release_handle;
	logic [BYTE_W-1:0]     byte_count;
	logic signed [EXP_W-1:0] ack_value;
	logic                  transfer_done;
	logic                  last;

	// Packets still to offer and results still owed by the block
	desc_t   pkt_queue[$];
	result_t due_results[$];

	// Shadow of the receiver state
	logic [EXP_W-1:0]    next_seq = '0;
	logic [EXP_W-1:0]    pkt_total = '0;
	logic [TOTAL_W-1:0]  size_bytes = '0;
	logic                slot_full[WINDOW];
	logic [HANDLE_W-1:0] slot_hdl[WINDOW];

	int gap_left = 0;
	bit no_gaps = 1'b0;
	int err_cnt = 0;
	int idle_cyc = 0;
	int plan_base = 0;

	reorder_window_receiver_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.size_ok       (size_ok),
		.seq_num       (seq_num),
		.payload_handle(payload_handle),
		.result_valid  (result_valid),
		.kind          (kind),
		.release_seq   (release_seq),
		.release_handle(release_handle),
		.byte_count    (byte_count),
		.ack_value     (ack_value),
		.transfer_done (transfer_done),
		.last          (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < WINDOW; i++) begin
			slot_full[i] = 1'b0;
			slot_hdl[i] = '0;
		end
	end

	// Predict one in-order release of packet s
	task automatic queue_release(input logic [EXP_W-1:0] s, input logic [HANDLE_W-1:0] h);
		result_t r;
		longint unsigned s64;
		s64 = s;
		r = '0;
		r.kind = KIND_RELEASE;
		r.rel_seq = s[SEQ_W-1:0];
		r.rel_handle = h;
		if ((s64 + 1) * PAYLOAD_BYTES > size_bytes)
			r.bytes = BYTE_W'(size_bytes % PAYLOAD_BYTES);
		else
			r.bytes = BYTE_W'(PAYLOAD_BYTES);
		r.done = ((s64 + 1) >= pkt_total);
		due_results.push_back(r);
	endtask

	// Work out every result caused by one accepted descriptor
	task automatic receive_packet(input logic ok, input logic [SEQ_W-1:0] seq,
			input logic [HANDLE_W-1:0] hdl);
		result_t r;
		logic [EXP_W-1:0] cur;
		logic [EXP_W-1:0] nxt;
		logic [EXP_W-1:0] s32;
		s32 = {1'b0, seq};
		if (!ok || s32 < next_seq)
			return;
		r = '0;
		r.kind = KIND_ACK;
		r.last = 1'b1;
		if (s32 == next_seq) begin
			// release this one, then drain consecutive buffered slots
			cur = s32;
			queue_release(cur, hdl);
			nxt = cur + 1;
			while (nxt <= 32'h7FFF_FFFF && slot_full[nxt[IDX_W-1:0]]) begin
				slot_full[nxt[IDX_W-1:0]] = 1'b0;
				queue_release(nxt, slot_hdl[nxt[IDX_W-1:0]]);
				cur = nxt;
				nxt = cur + 1;
			end
			next_seq = cur + 1;
			r.ack = cur;
			r.done = (next_seq >= pkt_total);
		end else begin
			// early: acknowledge the last in-order packet, buffer if new and in window
			r.ack = next_seq - 1;
			r.done = (next_seq >= pkt_total);
			if (s32 - next_seq < WINDOW && !slot_full[s32[IDX_W-1:0]]) begin
				slot_full[s32[IDX_W-1:0]] = 1'b1;
				slot_hdl[s32[IDX_W-1:0]] = hdl;
			end
		end
		due_results.push_back(r);
	endtask

	// Offer queued descriptors, hold while busy, idle with random gaps
	always @(posedge clk) begin : drive_items
		desc_t d;
		int r;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				receive_packet(size_ok, seq_num, payload_handle);
			if (start && busy) begin
				// hold the item until it is taken
			end else if (gap_left == 0 && pkt_queue.size() > 0) begin
				d = pkt_queue.pop_front();
				start <= 1'b1;
				size_ok <= d.ok;
				seq_num <= d.seq;
				payload_handle <= d.hdl;
				r = $urandom_range(0, 15);
				if (no_gaps || r < 8)
					gap_left <= 0;
				else if (r < 14)
					gap_left <= $urandom_range(1, 3);
				else
					gap_left <= $urandom_range(8, 40);
			end else begin
				start <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				size_ok <= 1'($urandom);
				seq_num <= SEQ_W'($urandom);
				payload_handle <= HANDLE_W'($urandom);
			end
		end
	end

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endtask

	// Compare each strobed result with the oldest prediction
	always @(posedge clk) begin : check_results
		result_t e;
		if (arst_n && result_valid) begin
			if (due_results.size() == 0) begin
				$error("result with nothing owed: kind %0b ack %0h", kind, ack_value);
				err_cnt++;
			end else begin
				e = due_results.pop_front();
				check_field("kind", e.kind, kind);
				check_field("release_seq", e.rel_seq, release_seq);
				check_field("release_handle", e.rel_handle, release_handle);
				check_field("byte_count", e.bytes, byte_count);
				check_field("ack_value", $unsigned(e.ack), $unsigned(ack_value));
				check_field("transfer_done", e.done, transfer_done);
				check_field("last", e.last, last);
			end
		end
	end

	// Stop the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic add_desc(input logic ok, input logic [SEQ_W-1:0] seq,
			input logic [HANDLE_W-1:0] hdl);
		desc_t d;
		d.ok = ok;
		d.seq = seq;
		d.hdl = hdl;
		pkt_queue.push_back(d);
	endtask

	// Wait until all items are out and all results are in, then settle
	task automatic wait_idle(input int settle);
		do
			@(negedge clk);
		while (pkt_queue.size() != 0 || start || due_results.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// Write the file size and update the shadow packet count
	task automatic write_size(input logic [TOTAL_W-1:0] v);
		longint unsigned n;
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_bytes = v;
		n = (longint'(v) + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
		if (n > 64'hFFFF_FFFF)
			n = 64'hFFFF_FFFF;
		pkt_total = n[EXP_W-1:0];
	endtask

	// Mostly whole blocks of consecutive packets in ascending, descending or random order, with noise mixed in
	task automatic gen_traffic(input int n_items);
		int cnt;
		int len;
		int r;
		int j;
		logic [SEQ_W-1:0] blk[$];
		logic [SEQ_W-1:0] t;
		cnt = 0;
		while (cnt < n_items) begin
			r = $urandom_range(0, 9);
			if (r < 7)
				len = $urandom_range(1, 8);
			else if (r < 9)
				len = $urandom_range(9, 24);
			else
				len = WINDOW;
			blk.delete();
			r = $urandom_range(0, 3);
			for (int i = 0; i < len; i++) begin
				if (r == 1)
					blk.push_front(SEQ_W'(plan_base + i));
				else
					blk.push_back(SEQ_W'(plan_base + i));
			end
			if (r >= 2) begin
				for (int i = len - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = blk[i];
					blk[i] = blk[j];
					blk[j] = t;
				end
			end
			for (int i = 0; i < len; i++) begin
				add_desc(1'b1, blk[i], HANDLE_W'($urandom));
				cnt++;
				if ($urandom_range(0, 5) == 0) begin
					case ($urandom_range(0, 4))
						0: begin
							// bad length, ignored
							add_desc(1'b0, $urandom_range(0, 1) ? blk[i] : SEQ_W'($urandom),
								HANDLE_W'($urandom));
						end
						1: begin
							// stale, ignored
							if (plan_base >= 4)
								add_desc(1'b1, SEQ_W'(plan_base - $urandom_range(1, 4)),
									HANDLE_W'($urandom));
						end
						2: begin
							// repeat of a packet of this block
							add_desc(1'b1, blk[$urandom_range(0, i)], HANDLE_W'($urandom));
							cnt++;
						end
						3: begin
							// early packet of a later block, leaving the next slot empty
							add_desc(1'b1, SEQ_W'(plan_base + len + 1 + $urandom_range(0, 20)),
								HANDLE_W'($urandom));
							cnt++;
						end
						default: begin
							// far beyond the window
							add_desc(1'b1, $urandom_range(0, 1) ? SEQ_W'($urandom) :
								SEQ_W'(plan_base + WINDOW + $urandom_range(0, 64)),
								HANDLE_W'($urandom));
							cnt++;
						end
					endcase
				end
			end
			plan_base += len;
		end
	endtask

	initial begin
		logic [TOTAL_W-1:0] sz;
		// Directed part under the reset size (no size given yet)
		add_desc(1'b0, 31'h7FFF_FFFF, 16'hFFFF);
		add_desc(1'b1, 31'd5, 16'hFFFF);
		add_desc(1'b1, 31'd5, 16'h1234);
		add_desc(1'b1, 31'd32, 16'h0001);
		add_desc(1'b1, 31'h7FFF_FFFF, 16'h0000);
		add_desc(1'b1, 31'd3, 16'hA5A5);
		add_desc(1'b1, 31'd2, 16'h5A5A);
		add_desc(1'b0, 31'd0, 16'h0000);
		add_desc(1'b1, 31'd0, 16'h0000);
		add_desc(1'b1, 31'd0, 16'hFFFF);
		add_desc(1'b1, 31'd1, 16'h0F0F);
		add_desc(1'b1, 31'd4, 16'hF0F0);
		add_desc(1'b1, 31'd2, 16'h1111);
		add_desc(1'b1, 31'd37, 16'h2222);
		add_desc(1'b1, 31'd38, 16'h3333);
		add_desc(1'b1, 31'd6, 16'h4444);
		plan_base = 7;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Random phases, each under its own file size
		for (int p = 0; p < 7; p++) begin
			wait_idle(4);
			case (p)
				0: sz = TOTAL_W'(plan_base + 20) * TOTAL_W'(PAYLOAD_BYTES) + 40'd700;
				1: sz = 40'hFF_FFFF_FFFF;
				2: sz = TOTAL_W'(plan_base + 30) * TOTAL_W'(PAYLOAD_BYTES);
				3: sz = 40'd1;
				4: sz = 40'd0;
				5: sz = TOTAL_W'({$urandom, $urandom});
				default: sz = TOTAL_W'(plan_base + 10) * TOTAL_W'(PAYLOAD_BYTES)
					+ TOTAL_W'($urandom_range(1, PAYLOAD_BYTES - 1));
			endcase
			write_size(sz);
			no_gaps = (p == 3);
			@(negedge clk);
			gen_traffic(32);
		end

		wait_idle(80);
		if (err_cnt == 0 && due_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
